@@ sv/symmetric_lag_difference_slope_core_macros.svh @@
// Assertion macros shared by the lag difference core modules.
`ifndef SYMMETRIC_LAG_DIFFERENCE_SLOPE_CORE_MACROS_SVH
`define SYMMETRIC_LAG_DIFFERENCE_SLOPE_CORE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define SLDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define SLDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/slds_pkg.sv @@
// Shared types and constants of the lag difference core.
package slds_pkg;

    localparam int LAG_W      = 5;
    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = 33;
    localparam int SLOPE_W    = 34;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAG      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MODE = 1'd1;

    // control bits of one job word sent from the front to the back
    typedef struct packed {
        logic wr;        // store the sample of this word in history
        logic has_diff;  // word yields a new difference
        logic last;      // closing word of a sequence
    } job_ctrl_t;

    localparam int JOB_CTRL_W = $bits(job_ctrl_t);

endpackage

@@ sv/slds_queue.sv @@
// Small register queue carrying job words from the front to the back.
module slds_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

`include "symmetric_lag_difference_slope_core_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    `SLDS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count past depth")

endmodule

@@ sv/slds_front.sv @@
// Front end: takes samples, tracks the sequence and issues job words.
module slds_front #(
    parameter int MAX_LAG = 16,
    parameter int ADDR_W  = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [slds_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                               s_end_of_series,
    input  logic [slds_pkg::LAG_W-1:0]         lag,
    input  logic                               q_full,
    output logic                               job_valid,
    output slds_pkg::job_ctrl_t                job_ctrl,
    output logic [slds_pkg::SAMPLE_W-1:0]      job_y,
    output logic [ADDR_W-1:0]                  job_wr_addr,
    output logic [ADDR_W-1:0]                  job_rd_addr
);

    import slds_pkg::*;

`include "symmetric_lag_difference_slope_core_macros.svh"

    localparam int COUNT_CAP = 2 * MAX_LAG + 2;
    localparam int CNT_W     = $clog2(COUNT_CAP + 1);
    localparam int CMP_W     = (CNT_W > LAG_W + 1) ? CNT_W : LAG_W + 1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_FINAL
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ADDR_W-1:0]     wp_reg;
    logic [LAG_W-1:0]      q_reg;
    logic [LAG_W-1:0]      k_reg;
    logic [SAMPLE_W-1:0]   fl_y_reg;
    logic [ADDR_W-1:0]     fl_wp_reg;
    logic [CNT_W-1:0]      fl_t_reg;

    logic [LAG_W-1:0]      lag_clamped;
    logic [LAG_W-1:0]      q_cur;
    logic [CMP_W-1:0]      t_ext;
    logic [CMP_W-1:0]      q_ext;
    logic [CMP_W-1:0]      q2_ext;
    logic [CMP_W-1:0]      ft_ext;
    logic [CMP_W-1:0]      kq_ext;
    logic [LAG_W-1:0]      kmax;
    logic                  accept;
    logic                  push;

    // lag of 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (lag == '0) begin
            lag_clamped = LAG_W'(1);
        end else if (CMP_W'(lag) > CMP_W'(MAX_LAG)) begin
            lag_clamped = LAG_W'(MAX_LAG);
        end else begin
            lag_clamped = lag;
        end
    end

    // lag is latched at the first sample of a sequence
    assign q_cur  = (cnt_reg == '0) ? lag_clamped : q_reg;
    assign t_ext  = CMP_W'(cnt_reg);
    assign q_ext  = CMP_W'(q_cur);
    assign q2_ext = q_ext << 1;
    assign ft_ext = CMP_W'(fl_t_reg);
    assign kq_ext = CMP_W'(k_reg) + CMP_W'(q_reg);
    assign kmax   = (t_ext >= q_ext) ? q_cur - 1'b1 : LAG_W'(cnt_reg);

    assign s_ready = (state_reg == ST_RUN) && !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = job_valid && !q_full;

    // job word for the current state
    always_comb begin
        job_valid   = 1'b0;
        job_ctrl    = '0;
        job_y       = '0;
        job_wr_addr = '0;
        job_rd_addr = '0;
        unique case (state_reg)
            ST_RUN: begin
                // new sample: store it, and it closes d(t-q) once t reaches q
                job_valid         = s_valid;
                job_ctrl.wr       = 1'b1;
                job_ctrl.has_diff = (t_ext >= q_ext);
                job_y             = s_sample;
                job_wr_addr       = wp_reg;
                job_rd_addr       = (t_ext >= q2_ext) ? wp_reg - ADDR_W'(q2_ext) : '0;
            end
            ST_FLUSH: begin
                // remaining index j = t-k, paired with the clamped older sample
                job_valid         = 1'b1;
                job_ctrl.has_diff = 1'b1;
                job_y             = fl_y_reg;
                job_rd_addr       = (ft_ext >= kq_ext)
                                  ? fl_wp_reg - ADDR_W'(k_reg) - ADDR_W'(q_reg) : '0;
            end
            ST_FINAL: begin
                job_valid     = 1'b1;
                job_ctrl.last = 1'b1;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    // sequence state and flush sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            wp_reg    <= '0;
            q_reg     <= LAG_W'(1);
            k_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_RUN: begin
                    if (accept) begin
                        q_reg <= q_cur;
                        if (s_end_of_series) begin
                            k_reg     <= kmax;
                            cnt_reg   <= '0;
                            wp_reg    <= '0;
                            state_reg <= ST_FLUSH;
                        end else begin
                            wp_reg <= wp_reg + 1'b1;
                            if (cnt_reg != CNT_W'(COUNT_CAP)) begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (push) begin
                        if (k_reg == '0) begin
                            state_reg <= ST_FINAL;
                        end else begin
                            k_reg <= k_reg - 1'b1;
                        end
                    end
                end
                ST_FINAL: begin
                    if (push) begin
                        state_reg <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // copy of the final sample for the flush words
    always_ff @(posedge aclk) begin
        if (accept && s_end_of_series) begin
            fl_y_reg  <= s_sample;
            fl_wp_reg <= wp_reg;
            fl_t_reg  <= cnt_reg;
        end
    end

    `SLDS_ASSERT_IMP(a_flush_k_range, state_reg == ST_FLUSH, k_reg < q_reg, "flush index past lag")
    `SLDS_ASSERT_NXT(a_final_starts_flush, accept && s_end_of_series, (state_reg == ST_FLUSH) && (cnt_reg == '0), "final sample did not start flush")

endmodule

@@ sv/slds_back.sv @@
// Back end: history memory, difference pipeline and result register.
module slds_back #(
    parameter int ADDR_W  = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  slds_pkg::job_ctrl_t                 h_ctrl,
    input  logic [slds_pkg::SAMPLE_W-1:0]       h_y,
    input  logic [ADDR_W-1:0]                   h_wr_addr,
    input  logic [ADDR_W-1:0]                   h_rd_addr,
    input  logic                                end_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [slds_pkg::DIFF_W-1:0]         m_abs_diff,
    output logic signed [slds_pkg::SLOPE_W-1:0] m_slope,
    output logic                                m_last_out
);

    import slds_pkg::*;

`include "symmetric_lag_difference_slope_core_macros.svh"

    localparam int HIST_DEPTH = 2 ** ADDR_W;

    logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic                b_valid_reg;
    job_ctrl_t           b_ctrl_reg;
    logic [SAMPLE_W-1:0] b_y_reg;

    logic                c_valid_reg;
    job_ctrl_t           c_ctrl_reg;
    logic [DIFF_W-1:0]   c_d_reg;

    logic                pending_valid_reg;
    logic [DIFF_W-1:0]   pending_diff_reg;
    logic [SLOPE_W-1:0]  prev_slope_reg;

    logic                m_valid_reg;
    logic [DIFF_W-1:0]   m_abs_diff_reg;
    logic [SLOPE_W-1:0]  m_slope_reg;
    logic                m_last_out_reg;

    logic                adv;
    logic [DIFF_W-1:0]   diff_pos;
    logic [DIFF_W-1:0]   diff_neg;
    logic [DIFF_W-1:0]   abs_d;
    logic [SLOPE_W-1:0]  slope_new;
    logic                emit_diff;
    logic                emit_last;
    logic                emit;
    logic [SLOPE_W-1:0]  out_slope;

    // whole pipeline moves when the result register is free or being taken
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    // history memory: one write, one registered read per cycle while the pipeline advances
    always_ff @(posedge aclk) begin
        if (q_pop && h_ctrl.wr) begin
            hist_mem[h_wr_addr] <= h_y;
        end
        if (adv) begin
            rd_data_reg <= hist_mem[h_rd_addr];
        end
    end

    // magnitude of new sample minus the older one
    assign diff_pos = {b_y_reg[SAMPLE_W-1], b_y_reg} - {rd_data_reg[SAMPLE_W-1], rd_data_reg};
    assign diff_neg = {rd_data_reg[SAMPLE_W-1], rd_data_reg} - {b_y_reg[SAMPLE_W-1], b_y_reg};
    assign abs_d    = diff_pos[DIFF_W-1] ? diff_neg : diff_pos;

    // forward difference against the pending value
    assign slope_new = {1'b0, c_d_reg} - {1'b0, pending_diff_reg};
    assign emit_diff = c_valid_reg && c_ctrl_reg.has_diff && pending_valid_reg;
    assign emit_last = c_valid_reg && c_ctrl_reg.last;
    assign emit      = emit_diff || emit_last;
    assign out_slope = emit_last ? (end_mode ? prev_slope_reg : '0) : slope_new;

    // control and difference state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg       <= 1'b0;
            c_valid_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            pending_valid_reg <= 1'b0;
            pending_diff_reg  <= '0;
            prev_slope_reg    <= '0;
        end else if (adv) begin
            b_valid_reg <= q_pop;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= emit;
            if (c_valid_reg && c_ctrl_reg.has_diff) begin
                pending_diff_reg  <= c_d_reg;
                pending_valid_reg <= 1'b1;
                if (pending_valid_reg) begin
                    prev_slope_reg <= slope_new;
                end
            end
            if (emit_last) begin
                pending_valid_reg <= 1'b0;
                prev_slope_reg    <= '0;
            end
        end
    end

    // stage payloads and result word
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (q_pop) begin
                b_ctrl_reg <= h_ctrl;
                b_y_reg    <= h_y;
            end
            c_ctrl_reg <= b_ctrl_reg;
            c_d_reg    <= abs_d;
            if (emit) begin
                m_abs_diff_reg <= pending_diff_reg;
                m_slope_reg    <= out_slope;
                m_last_out_reg <= emit_last;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_abs_diff = m_abs_diff_reg;
    assign m_slope    = m_slope_reg;
    assign m_last_out = m_last_out_reg;

    `SLDS_ASSERT_IMP(a_last_has_pending, adv && emit_last, pending_valid_reg, "closing word without pending difference")
    `SLDS_ASSERT_NXT(a_last_clears, adv && emit_last, !pending_valid_reg && (prev_slope_reg == '0), "sequence state not cleared after closing word")

endmodule

@@ sv/symmetric_lag_difference_slope_core.sv @@
// Top level of the lag difference core: configuration, queue and wiring.
//
// Streams signed Q16.16 samples and returns d(i) = |y(min(i+q,n-1)) - y(max(i-q,0))|
// with its forward difference d(i+1)-d(i); the result for the final index carries
// last_out and a slope of zero or the previous slope, per end_mode. While a
// sequence streams, one sample is taken per clock while the queue has room, and
// each sample from index q+1 on yields one result. Each job word passes the queue,
// the read stage and the difference stage, then the result register.
// The flagged final sample holds s_ready low while the front issues min(n,q) flush
// words and the closing word, one per cycle while the queue has room. The history
// memory holds 2**ceil(log2(2*MAX_LAG+1)) words with one write and one registered
// read per cycle while the pipeline advances; it needs no clearing after reset. The
// lag is latched at the first sample of each sequence. The user must write registers
// via cfg_wr_en/cfg_index/cfg_data while the core is idle; this is not enforced.
module symmetric_lag_difference_slope_core #(
    parameter int MAX_LAG     = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [slds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [slds_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_end_of_series,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [slds_pkg::DIFF_W-1:0]         m_abs_diff,
    output logic signed [slds_pkg::SLOPE_W-1:0] m_slope,
    output logic                                m_last_out
);

    import slds_pkg::*;

    localparam int ADDR_W = $clog2(2 * MAX_LAG + 1);
    localparam int JOB_W  = JOB_CTRL_W + SAMPLE_W + 2 * ADDR_W;

    logic [LAG_W-1:0]    lag_reg;
    logic                end_mode_reg;

    logic                job_valid;
    job_ctrl_t           job_ctrl;
    logic [SAMPLE_W-1:0] job_y;
    logic [ADDR_W-1:0]   job_wr_addr;
    logic [ADDR_W-1:0]   job_rd_addr;

    logic [JOB_W-1:0]    q_wdata;
    logic [JOB_W-1:0]    q_rdata;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;

    job_ctrl_t           h_ctrl;
    logic [SAMPLE_W-1:0] h_y;
    logic [ADDR_W-1:0]   h_wr_addr;
    logic [ADDR_W-1:0]   h_rd_addr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg      <= LAG_W'(1);
            end_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LAG:      lag_reg      <= cfg_data[LAG_W-1:0];
                REG_END_MODE: end_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    slds_front #(
        .MAX_LAG (MAX_LAG),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_end_of_series (s_end_of_series),
        .lag             (lag_reg),
        .q_full          (q_full),
        .job_valid       (job_valid),
        .job_ctrl        (job_ctrl),
        .job_y           (job_y),
        .job_wr_addr     (job_wr_addr),
        .job_rd_addr     (job_rd_addr)
    );

    // job word packing through the queue
    assign q_wdata = {job_ctrl, job_y, job_wr_addr, job_rd_addr};
    assign {h_ctrl, h_y, h_wr_addr, h_rd_addr} = q_rdata;

    slds_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_valid),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    slds_back #(
        .ADDR_W  (ADDR_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .h_ctrl     (h_ctrl),
        .h_y        (h_y),
        .h_wr_addr  (h_wr_addr),
        .h_rd_addr  (h_rd_addr),
        .end_mode   (end_mode_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_abs_diff (m_abs_diff),
        .m_slope    (m_slope),
        .m_last_out (m_last_out)
    );

endmodule

@@ verif/slds_scoreboard.sv @@
// Scoreboard for the lag difference core: predicts each result word and checks the m_ side.
module slds_scoreboard #(
    parameter int MAX_LAG = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [slds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slds_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [slds_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_end_of_series,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [slds_pkg::DIFF_W-1:0]          m_abs_diff,
    input  logic signed [slds_pkg::SLOPE_W-1:0]  m_slope,
    input  logic                                 m_last_out,
    output int unsigned                          errors,
    output int unsigned                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import slds_pkg::*;

    localparam int HIST_LEN  = 2 * MAX_LAG + 1;
    localparam int COUNT_SAT = 2 * MAX_LAG + 2;

    typedef struct packed {
        logic [DIFF_W-1:0]         abs_diff;
        logic signed [SLOPE_W-1:0] slope;
        logic                      last;
    } slope_result_t;

    slope_result_t expected_results [$];

    // register copies
    logic [LAG_W-1:0] lag_reg;
    logic             end_mode_reg;

    // per-series state
    logic signed [SAMPLE_W-1:0] history [0:HIST_LEN-1];
    logic signed [SAMPLE_W-1:0] first_y;
    longint                     pend_diff;
    bit                         pend_ok;
    longint                     last_slope;
    int                         seen;
    int                         series_lag;

    function automatic void clear_series();
        for (int i = 0; i < HIST_LEN; i++) history[i] = '0;
        first_y    = '0;
        pend_diff  = 0;
        pend_ok    = 1'b0;
        last_slope = 0;
        seen       = 0;
        series_lag = 1;
    endfunction

    function automatic longint series_diff(logic signed [SAMPLE_W-1:0] y,
                                           logic signed [SAMPLE_W-1:0] prior);
        longint d;
        d = longint'(y) - longint'(prior);
        return (d < 0) ? -d : d;
    endfunction

    // takes the next difference; the pending one leaves with its forward slope
    function automatic void emit_pending(longint d_new);
        slope_result_t res;
        longint        s;
        if (pend_ok) begin
            s            = d_new - pend_diff;
            res.abs_diff = pend_diff[DIFF_W-1:0];
            res.slope    = s[SLOPE_W-1:0];
            res.last     = 1'b0;
            expected_results.push_back(res);
            last_slope = s;
        end
        pend_diff = d_new;
        pend_ok   = 1'b1;
    endfunction

    function automatic void predict_series_word(logic signed [SAMPLE_W-1:0] y, logic eos);
        slope_result_t res;
        int            t;
        int            q;
        int            kmax;
        t = seen;
        // lag is latched on the first sample, clamped to 1..MAX_LAG
        if (t == 0) begin
            series_lag = int'(lag_reg);
            if (series_lag < 1) series_lag = 1;
            if (series_lag > MAX_LAG) series_lag = MAX_LAG;
            first_y = y;
        end
        q = series_lag;
        for (int i = HIST_LEN - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = y;
        // newest sample closes d(t-q)
        if (t >= q) emit_pending(series_diff(y, (t >= 2 * q) ? history[2*q] : first_y));
        if (seen < COUNT_SAT) seen++;
        if (eos) begin
            // flush the tail indices with the top end clamped to this sample
            kmax = (t >= q) ? q - 1 : t;
            for (int k = kmax; k >= 0; k--)
                emit_pending(series_diff(y, (t - k >= q) ? history[k+q] : first_y));
            res.abs_diff = pend_diff[DIFF_W-1:0];
            res.slope    = end_mode_reg ? last_slope[SLOPE_W-1:0] : '0;
            res.last     = 1'b1;
            expected_results.push_back(res);
            clear_series();
        end
    endfunction

    always @(posedge aclk) begin
        slope_result_t want;
        if (!aresetn) begin
            lag_reg      = LAG_W'(1);
            end_mode_reg = 1'b0;
            clear_series();
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LAG:      lag_reg      = cfg_data[LAG_W-1:0];
                    REG_END_MODE: end_mode_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_series_word(s_sample, s_end_of_series);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: abs_diff %0d slope %0d last_out %0b",
                           m_abs_diff, m_slope, m_last_out);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_abs_diff !== want.abs_diff) begin
                        $error("abs_diff: expected %0d, actual %0d", want.abs_diff, m_abs_diff);
                        errors++;
                    end
                    if (m_slope !== want.slope) begin
                        $error("slope: expected %0d, actual %0d", want.slope, m_slope);
                        errors++;
                    end
                    if (m_last_out !== want.last) begin
                        $error("last_out: expected %0b, actual %0b", want.last, m_last_out);
                        errors++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ verif/testbench.sv @@
// Top of the lag difference core testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slds_pkg::*;

    localparam int MAX_LAG        = 16;
    localparam int RANDOM_WORDS   = 240;
    localparam int DRAIN_PAD      = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_sample;
    logic                         s_end_of_series;
    logic                         m_valid;
    logic                         m_ready;
    logic [DIFF_W-1:0]            m_abs_diff;
    logic signed [SLOPE_W-1:0]    m_slope;
    logic                         m_last_out;

    int unsigned errors;
    int unsigned outstanding;
    bit          idle_en = 1'b1;
    int          quiet_cycles = 0;

    symmetric_lag_difference_slope_core #(.MAX_LAG(MAX_LAG)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_end_of_series (s_end_of_series),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_abs_diff      (m_abs_diff),
        .m_slope         (m_slope),
        .m_last_out      (m_last_out)
    );

    slds_scoreboard #(.MAX_LAG(MAX_LAG)) u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_end_of_series (s_end_of_series),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_abs_diff      (m_abs_diff),
        .m_slope         (m_slope),
        .m_last_out      (m_last_out),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= !idle_en || ($urandom_range(0, 99) >= 15);
        end
    end

    // no handshake for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one register write; entered and left at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input int unsigned lag, input int unsigned mode);
        write_reg(REG_LAG, lag);
        write_reg(REG_END_MODE, mode);
    endtask

    // send one word, with random idle cycles ahead of it
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic eos);
        while (idle_en && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_sample        <= smp;
        s_end_of_series <= eos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // hold off the sender until every expected word has come, then pad
    task automatic drain(input int pad);
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (pad) @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: begin
                v = $urandom_range(0, 196608);
                return v - 98304;
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int phase;
        int len;
        int lag;
        int sel;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_sample        = '0;
        s_end_of_series = 1'b0;
        aresetn         = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // lag 0 acts as 1: single sample, then full-scale swings
        set_config(0, 0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        drain(DRAIN_PAD);

        // lag above range clamps to MAX_LAG; single sample repeats nothing
        set_config(31, 1);
        send_word(-32'sh0005_0000, 1'b1);
        send_word(32'sh0001_0000, 1'b0);
        send_word(32'sh0003_8000, 1'b0);
        send_word(-32'sh0002_0000, 1'b0);
        send_word(32'sh0000_0001, 1'b0);
        send_word(32'sh7FFF_0000, 1'b1);
        drain(DRAIN_PAD);

        // registers change mid-series while the core is drained
        set_config(2, 0);
        send_word(32'sh0000_1000, 1'b0);
        send_word(32'sh0010_0000, 1'b0);
        send_word(-32'sh0010_0000, 1'b0);
        send_word(32'sh0002_0000, 1'b0);
        drain(DRAIN_PAD);
        set_config(5, 1);
        send_word(32'sh0004_0000, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-32'sh0001_0000, 1'b0);
        send_word(32'sh0006_0000, 1'b1);
        drain(DRAIN_PAD);

        // random phases: new settings, a few series each
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            idle_en = (phase != 2);
            sel = $urandom_range(0, 5);
            case (sel)
                0: lag = 0;
                1: lag = 1;
                2: lag = MAX_LAG;
                3: lag = 31;
                4: lag = $urandom_range(1, MAX_LAG);
                default: lag = $urandom_range(0, 31);
            endcase
            set_config(lag, $urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) len = $urandom_range(1, 12);
                else if (sel < 9) len = $urandom_range(13, 40);
                else len = $urandom_range(41, 70);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 49) == 0) drain(0);
                    send_word(pick_sample(), i == len - 1);
                    sent++;
                end
            end
            drain(DRAIN_PAD);
            phase++;
        end
        idle_en = 1'b1;

        drain(DRAIN_PAD);
        if (errors == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/slds_pkg.sv
sv/slds_queue.sv
sv/slds_front.sv
sv/slds_back.sv
sv/symmetric_lag_difference_slope_core.sv
verif/slds_scoreboard.sv
verif/testbench.sv
